// ===== sv/pot_level_to_step_pulses_macros.svh =====
// Assertion macros shared by the step pulse design
`ifndef POT_LEVEL_TO_STEP_PULSES_MACROS_SVH
`define POT_LEVEL_TO_STEP_PULSES_MACROS_SVH

// Condition must hold at every clock edge out of reset
`define PLSP_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define PLSP_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle
`define PLSP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/plsp_pkg.sv =====
// Types and constants for the potentiometer step pulse block
package plsp_pkg;

    localparam int RD_W        = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int STEP_W      = 7;
    localparam int LIM_W       = 4;
    localparam int PCT_PROD_W  = 14;
    localparam int DIV_NUM_W   = 19;
    localparam int DIV_DEN_W   = 12;
    localparam int DIV_CNT_W   = 5;

    localparam logic [DIV_CNT_W-1:0] TGT_STEPS = 5'd19;
    localparam logic [DIV_CNT_W-1:0] PCT_STEPS = 5'd14;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_ADC_FLOOR   = 3'd0;
    localparam cfg_idx_t CFG_ADC_CEILING = 3'd1;
    localparam cfg_idx_t CFG_HYSTERESIS  = 3'd2;
    localparam cfg_idx_t CFG_MAX_STEPS   = 3'd3;
    localparam cfg_idx_t CFG_VOL_FULL    = 3'd4;
    localparam cfg_idx_t CFG_BRI_FULL    = 3'd5;

    localparam logic [RD_W-1:0]   RST_ADC_FLOOR   = 12'd150;
    localparam logic [RD_W-1:0]   RST_ADC_CEILING = 12'd3900;
    localparam logic [STEP_W-1:0] RST_HYSTERESIS  = 7'd2;
    localparam logic [LIM_W-1:0]  RST_MAX_STEPS   = 4'd3;
    localparam logic [STEP_W-1:0] RST_VOL_FULL    = 7'd50;
    localparam logic [STEP_W-1:0] RST_BRI_FULL    = 7'd100;

    localparam logic [7:0] USAGE_VOL_UP   = 8'hE9;
    localparam logic [7:0] USAGE_VOL_DOWN = 8'hEA;
    localparam logic [7:0] USAGE_BRI_UP   = 8'h6F;
    localparam logic [7:0] USAGE_BRI_DOWN = 8'h70;

    localparam logic [PCT_PROD_W-1:0] PCT_SCALE = 14'd100;
    localparam logic [STEP_W-1:0]     PCT_MAX   = 7'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_TGT,
        ST_DECIDE,
        ST_DIV_PCT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_CNT_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_stat_t;

endpackage

// ===== sv/plsp_div.sv =====
// Shared restoring divider, one quotient bit per cycle
module plsp_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  plsp_pkg::div_req_t  req,
    output plsp_pkg::div_stat_t stat
);

    logic [plsp_pkg::DIV_NUM_W-1:0] q_reg, q_next;
    logic [plsp_pkg::DIV_DEN_W-1:0] r_reg, r_next;
    logic [plsp_pkg::DIV_DEN_W-1:0] d_reg;
    logic [plsp_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [plsp_pkg::DIV_DEN_W:0]   trial;
    logic                           fits;

    // Shift the next numerator bit into the remainder and try the subtract
    always_comb begin
        trial  = {r_reg, q_reg[plsp_pkg::DIV_NUM_W-1]};
        fits   = trial >= {1'b0, d_reg};
        r_next = fits ? plsp_pkg::DIV_DEN_W'(trial - {1'b0, d_reg})
                      : plsp_pkg::DIV_DEN_W'(trial);
        q_next = {q_reg[plsp_pkg::DIV_NUM_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == plsp_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            q_reg <= req.num;
            r_reg <= '0;
            d_reg <= req.den;
        end else if (busy_reg) begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.quot = q_reg;

endmodule

// ===== sv/pot_level_to_step_pulses.sv =====
// Top level: potentiometer reading to volume / brightness step pulses
// The level map division runs when the reading lies above the floor, the span is not
//   empty and the channel has nonzero full steps; the percent division runs for every
//   pulsing poll unless the channel has zero full steps. Both share one bit-serial divider.
// Throughput: one poll at a time; a new poll is accepted only back in idle, after the
//   last pulse transfers (pulses wait on m_tready) or after a poll with no pulse.
// Reset: synchronous active-low; registers return to defaults, levels unknown.
`include "pot_level_to_step_pulses_macros.svh"

module pot_level_to_step_pulses #(
    parameter int NUM_CHANNELS = 2,
    parameter int ADC_BITS     = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration writes
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [11:0] cfg_wr_data,
    // Poll input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] reading, [15:12] zero
    input  logic [0:0]  s_tuser,   // [0] channel
    // Pulse output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] usage_code, [14:8] level_after,
                                   // [21:15] percent, [23:22] zero
    output logic [1:0]  m_tuser,   // [0] out_channel, [1] decrement
    output logic        m_tlast    // last
);

    localparam int RD_W   = plsp_pkg::RD_W;
    localparam int STEP_W = plsp_pkg::STEP_W;
    localparam int LIM_W  = plsp_pkg::LIM_W;
    localparam int NUM_W  = plsp_pkg::DIV_NUM_W;
    localparam int DEN_W  = plsp_pkg::DIV_DEN_W;
    localparam int PAD_W  = plsp_pkg::DIV_NUM_W - plsp_pkg::PCT_PROD_W;
    // Keep only the converter's own bits of the reading
    localparam logic [RD_W-1:0] RD_MASK = RD_W'((64'd1 << ADC_BITS) - 64'd1);

    // Configuration registers
    logic [RD_W-1:0]   floor_reg;
    logic [RD_W-1:0]   ceil_reg;
    logic [STEP_W-1:0] hyst_reg;
    logic [LIM_W-1:0]  max_reg;
    logic [STEP_W-1:0] vol_full_reg;
    logic [STEP_W-1:0] bri_full_reg;

    // Per-channel state
    logic [STEP_W-1:0] sent_reg  [NUM_CHANNELS];
    logic              known_reg [NUM_CHANNELS];

    // Sequencer and poll registers
    plsp_pkg::state_t  state_reg, state_next;
    logic              ch_reg;
    logic [RD_W-1:0]   rd_reg;
    logic [STEP_W-1:0] target_reg;
    logic [LIM_W-1:0]  mag_reg;
    logic [LIM_W-1:0]  k_reg;
    logic              down_reg;
    logic [STEP_W-1:0] lvl_reg;
    logic [STEP_W-1:0] pct_reg;

    plsp_pkg::div_req_t  div_req;
    plsp_pkg::div_stat_t div_stat;

    // Datapath helpers
    logic              ch_ok;
    logic [STEP_W-1:0] full_sel;
    logic              full_zero;
    logic              map_direct;
    logic [STEP_W-1:0] map_direct_val;
    logic [RD_W-1:0]   rd_ofs;
    logic [RD_W-1:0]   span;
    logic [NUM_W-1:0]  map_prod;
    logic              known_cur;
    logic [STEP_W-1:0] sent_cur;
    logic [STEP_W-1:0] sent_eff;
    logic              down;
    logic [STEP_W-1:0] mag_full;
    logic [LIM_W-1:0]  mag_clamp;
    logic              skip;
    logic [STEP_W-1:0] sent_new;
    logic [plsp_pkg::PCT_PROD_W-1:0] pct_prod;
    logic [STEP_W-1:0] tgt_clamp;
    logic [STEP_W-1:0] pct_clamp;
    logic              last_pulse;
    logic [7:0]        usage;

    plsp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .stat    (div_stat)
    );

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg    <= plsp_pkg::RST_ADC_FLOOR;
            ceil_reg     <= plsp_pkg::RST_ADC_CEILING;
            hyst_reg     <= plsp_pkg::RST_HYSTERESIS;
            max_reg      <= plsp_pkg::RST_MAX_STEPS;
            vol_full_reg <= plsp_pkg::RST_VOL_FULL;
            bri_full_reg <= plsp_pkg::RST_BRI_FULL;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                plsp_pkg::CFG_ADC_FLOOR:   floor_reg    <= cfg_wr_data[RD_W-1:0];
                plsp_pkg::CFG_ADC_CEILING: ceil_reg     <= cfg_wr_data[RD_W-1:0];
                plsp_pkg::CFG_HYSTERESIS:  hyst_reg     <= cfg_wr_data[STEP_W-1:0];
                plsp_pkg::CFG_MAX_STEPS:   max_reg      <= cfg_wr_data[LIM_W-1:0];
                plsp_pkg::CFG_VOL_FULL:    vol_full_reg <= cfg_wr_data[STEP_W-1:0];
                plsp_pkg::CFG_BRI_FULL:    bri_full_reg <= cfg_wr_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        ch_ok     = int'(ch_reg) < NUM_CHANNELS;
        full_sel  = ch_reg ? bri_full_reg : vol_full_reg;
        full_zero = full_sel == '0;

        // Map: zero at or below the floor, full when the span is empty,
        // otherwise (reading - floor) * full / span through the divider
        map_direct     = full_zero || (rd_reg <= floor_reg) || (ceil_reg <= floor_reg);
        map_direct_val = (full_zero || (rd_reg <= floor_reg)) ? '0 : full_sel;
        rd_ofs         = rd_reg - floor_reg;
        span           = ceil_reg - floor_reg;
        map_prod       = NUM_W'(rd_ofs) * NUM_W'(full_sel);

        tgt_clamp = (div_stat.quot > NUM_W'(full_sel)) ? full_sel
                                                        : div_stat.quot[STEP_W-1:0];
        pct_clamp = (div_stat.quot > NUM_W'(plsp_pkg::PCT_MAX)) ? plsp_pkg::PCT_MAX
                                                                : div_stat.quot[STEP_W-1:0];

        known_cur = 1'b0;
        sent_cur  = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (int'(ch_reg) == i) begin
                known_cur = known_reg[i];
                sent_cur  = sent_reg[i];
            end
        end

        // First poll of a channel loads the target, so nothing moves
        sent_eff  = known_cur ? sent_cur : target_reg;
        down      = target_reg < sent_eff;
        mag_full  = down ? (sent_eff - target_reg) : (target_reg - sent_eff);
        mag_clamp = (mag_full > STEP_W'(max_reg)) ? max_reg : mag_full[LIM_W-1:0];
        skip      = (mag_full == '0) || (mag_full < hyst_reg) || (mag_clamp == '0);
        sent_new  = down ? (sent_eff - STEP_W'(mag_clamp)) : (sent_eff + STEP_W'(mag_clamp));
        pct_prod  = plsp_pkg::PCT_PROD_W'(sent_new) * plsp_pkg::PCT_SCALE;

        last_pulse = k_reg == (mag_reg - 1'b1);
        if (ch_reg) begin
            usage = down_reg ? plsp_pkg::USAGE_BRI_DOWN : plsp_pkg::USAGE_BRI_UP;
        end else begin
            usage = down_reg ? plsp_pkg::USAGE_VOL_DOWN : plsp_pkg::USAGE_VOL_UP;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            plsp_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = plsp_pkg::ST_PREP;
            end
            plsp_pkg::ST_PREP: begin
                if (!ch_ok)          state_next = plsp_pkg::ST_IDLE;
                else if (map_direct) state_next = plsp_pkg::ST_DECIDE;
                else                 state_next = plsp_pkg::ST_DIV_TGT;
            end
            plsp_pkg::ST_DIV_TGT: begin
                if (div_stat.done) state_next = plsp_pkg::ST_DECIDE;
            end
            plsp_pkg::ST_DECIDE: begin
                if (skip)           state_next = plsp_pkg::ST_IDLE;
                else if (full_zero) state_next = plsp_pkg::ST_EMIT;
                else                state_next = plsp_pkg::ST_DIV_PCT;
            end
            plsp_pkg::ST_DIV_PCT: begin
                if (div_stat.done) state_next = plsp_pkg::ST_EMIT;
            end
            plsp_pkg::ST_EMIT: begin
                if (m_tready && last_pulse) state_next = plsp_pkg::ST_IDLE;
            end
            default: state_next = plsp_pkg::ST_IDLE;
        endcase
    end

    // Handshake and divider requests
    always_comb begin
        s_tready      = state_reg == plsp_pkg::ST_IDLE;
        m_tvalid      = state_reg == plsp_pkg::ST_EMIT;
        div_req.start = 1'b0;
        div_req.num   = map_prod;
        div_req.den   = span;
        div_req.steps = plsp_pkg::TGT_STEPS;
        case (state_reg)
            plsp_pkg::ST_PREP: begin
                div_req.start = ch_ok && !map_direct;
            end
            plsp_pkg::ST_DECIDE: begin
                // Align the 14-bit product high so 14 steps give the quotient
                div_req.start = !skip && !full_zero;
                div_req.num   = {pct_prod, PAD_W'(0)};
                div_req.den   = DEN_W'(full_sel);
                div_req.steps = plsp_pkg::PCT_STEPS;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= plsp_pkg::ST_IDLE;
        else          state_reg <= state_next;
    end

    // Channel levels
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                sent_reg[i]  <= '0;
                known_reg[i] <= 1'b0;
            end
        end else if (state_reg == plsp_pkg::ST_DECIDE) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (int'(ch_reg) == i) begin
                    known_reg[i] <= 1'b1;
                    sent_reg[i]  <= skip ? sent_eff : sent_new;
                end
            end
        end
    end

    // Poll datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg   <= '0;
            mag_reg <= '0;
        end else begin
            case (state_reg)
                plsp_pkg::ST_IDLE: begin
                    if (s_tvalid) begin
                        ch_reg <= s_tuser[0];
                        rd_reg <= s_tdata[RD_W-1:0] & RD_MASK;
                    end
                end
                plsp_pkg::ST_PREP: begin
                    target_reg <= map_direct_val;
                end
                plsp_pkg::ST_DIV_TGT: begin
                    if (div_stat.done) target_reg <= tgt_clamp;
                end
                plsp_pkg::ST_DECIDE: begin
                    mag_reg  <= mag_clamp;
                    down_reg <= down;
                    lvl_reg  <= sent_new;
                    pct_reg  <= '0;
                    k_reg    <= '0;
                end
                plsp_pkg::ST_DIV_PCT: begin
                    if (div_stat.done) pct_reg <= pct_clamp;
                end
                plsp_pkg::ST_EMIT: begin
                    // Advance the pulse count on each transfer
                    if (m_tready) k_reg <= k_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign m_tdata = {2'b00, pct_reg, lvl_reg, usage};
    assign m_tuser = {down_reg, ch_reg};
    assign m_tlast = last_pulse;

    `PLSP_ASSERT_ALWAYS(a_ready_excl, aclk, aresetn, !(s_tready && m_tvalid), "input and output both open")
    `PLSP_ASSERT_IMPLY(a_emit_count, aclk, aresetn, m_tvalid, (mag_reg != '0) && (k_reg < mag_reg), "pulse count out of range")
    `PLSP_ASSERT_NEXT(a_last_idle, aclk, aresetn, m_tvalid && m_tready && m_tlast, s_tready, "no return to idle after last pulse")
    `PLSP_ASSERT_IMPLY(a_div_quiet, aclk, aresetn, (state_reg == plsp_pkg::ST_DECIDE) || (state_reg == plsp_pkg::ST_EMIT), !div_stat.busy, "divider busy outside division")

endmodule
